// ----- rtl/ppfl_pkg.sv -----
// ppfl_pkg: shared types and constants of the per-cpu page free list allocator
// no dependencies; compiled before every other file of the block
package ppfl_pkg;

    // page geometry
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PG_W       = 32 - PAGE_SHIFT;  // page number bits
    localparam int unsigned BP_W       = PG_W + 1;         // rounded-up base page bits
    localparam int unsigned DIFF_W     = BP_W + 1;         // signed page offset bits

    // opcode of a request
    localparam logic OP_FREE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // register indexes (byte address bit 2)
    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

    // register reset values
    localparam logic [31:0] LOW_RESET  = 32'h8000_0000;
    localparam logic [31:0] HIGH_RESET = 32'h8800_0000;
    localparam logic [32:0] LOW_RND    = 33'(LOW_RESET) + 33'((1 << PAGE_SHIFT) - 1);
    localparam logic [BP_W-1:0] BP_RESET = LOW_RND[32:PAGE_SHIFT];

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_HEAD,
        S_LINK,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_req;     // capture request, start scan at requester
        logic free_commit;  // check free address and push
        logic head_read;    // read link of current head
        logic scan_next;    // move to next cpu list
        logic oom;          // record out of memory
        logic pop_commit;   // unlink head, record page
        logic out_load;     // move result into output register
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic head_valid;   // current list is nonempty
        logic scan_last;    // all other lists tried
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage

// ----- rtl/ppfl_if.sv -----
// ppfl_req_if / ppfl_rsp_if: request and response channels of the allocator
// payload widths are fixed; no package dependency
interface ppfl_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  requester_cpu;
    logic [31:0] phys_addr;

    modport source (output valid, output opcode, output requester_cpu, output phys_addr,
                    input ready);
    modport sink   (input valid, input opcode, input requester_cpu, input phys_addr,
                    output ready);
endinterface

interface ppfl_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] page_addr;
    logic [1:0]  status;
    logic [2:0]  source_cpu;

    modport source (output valid, output page_addr, output status, output source_cpu,
                    input ready);
    modport sink   (input valid, input page_addr, input status, input source_cpu,
                    output ready);
endinterface

// ----- rtl/ppfl_ram.sv -----
// ppfl_ram: generic single write port, single read port ram with registered read
// no dependencies
module ppfl_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ppfl_ctrl.sv -----
// ppfl_ctrl: request sequencer of the page allocator
// depends on ppfl_pkg for state, command and status types
module ppfl_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_free,
    input  ppfl_pkg::t_dp_status   i_sts,
    output logic                   o_in_ready,
    output ppfl_pkg::t_ctrl_cmd    o_cmd
);

    ppfl_pkg::t_state r_state;
    ppfl_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ppfl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = i_in_free ? ppfl_pkg::S_FREE : ppfl_pkg::S_HEAD;
                end
            end
            ppfl_pkg::S_FREE: begin
                o_cmd.free_commit = 1'b1;
                n_state = ppfl_pkg::S_DONE;
            end
            ppfl_pkg::S_HEAD: begin
                if (i_sts.head_valid) begin
                    o_cmd.head_read = 1'b1;
                    n_state = ppfl_pkg::S_LINK;
                end else if (i_sts.scan_last) begin
                    o_cmd.oom = 1'b1;
                    n_state = ppfl_pkg::S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ppfl_pkg::S_LINK: begin
                o_cmd.pop_commit = 1'b1;
                n_state = ppfl_pkg::S_DONE;
            end
            ppfl_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ppfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ppfl_dp.sv -----
// ppfl_dp: list heads, link ram, free address check and result registers
// depends on ppfl_pkg and ppfl_ram
module ppfl_dp #(
    parameter int unsigned NUM_CPUS  = 8,
    parameter int unsigned NUM_PAGES = 32768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppfl_pkg::t_ctrl_cmd             i_cmd,
    output ppfl_pkg::t_dp_status            o_sts,
    input  logic [2:0]                      i_cpu,
    input  logic [31:0]                     i_addr,
    input  logic [31:0]                     i_low,
    input  logic [31:0]                     i_high,
    input  logic [ppfl_pkg::BP_W-1:0]       i_bp,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [31:0]                     o_page_addr,
    output logic [1:0]                      o_status,
    output logic [2:0]                      o_source_cpu
);

    localparam int unsigned CW = $clog2(NUM_CPUS);
    localparam int unsigned SW = $clog2(NUM_PAGES);
    localparam logic [4:0]  NCPU      = 5'(NUM_CPUS);
    localparam logic [CW-1:0] CPU_LAST = CW'(NUM_CPUS - 1);
    localparam logic [ppfl_pkg::BP_W-1:0] NPAGES = ppfl_pkg::BP_W'(NUM_PAGES);

    // request and scan registers
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_addr, n_addr;

    // list heads
    logic [SW-1:0]       r_head_slot [NUM_CPUS];
    logic [SW-1:0]       n_head_slot [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_head_vld, n_head_vld;

    // pending result and output register
    logic [31:0] r_res_addr, n_res_addr;
    logic [1:0]  r_res_status, n_res_status;
    logic [2:0]  r_res_src, n_res_src;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_addr;
    logic [1:0]  r_out_status;
    logic [2:0]  r_out_src;

    // link ram ports
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [SW:0]   ram_wdata;
    logic          ram_re;
    logic [SW-1:0] ram_raddr;
    logic [SW:0]   ram_rdata;

    // derived values
    logic [CW-1:0]                   cpu_mod;
    logic [4:0]                      cpu_red;
    logic                            free_bad;
    logic [ppfl_pkg::DIFF_W-1:0]     pg_diff;
    logic [SW-1:0]                   free_slot;
    logic [SW-1:0]                   cur_slot;
    logic [ppfl_pkg::BP_W-1:0]       page_sum;
    logic [3:0]                      cur_wide;

    // requester cpu modulo the cpu count, by repeated subtraction
    always_comb begin
        cpu_red = {2'b00, i_cpu};
        for (int i = 0; i < 3; i++) begin
            if (cpu_red >= NCPU) begin
                cpu_red = cpu_red - NCPU;
            end
        end
        cpu_mod = cpu_red[CW-1:0];
    end

    // free address check and slot number
    always_comb begin
        pg_diff   = {2'b00, r_addr[31:ppfl_pkg::PAGE_SHIFT]} - {1'b0, i_bp};
        free_slot = pg_diff[SW-1:0];
        free_bad  = (r_addr[ppfl_pkg::PAGE_SHIFT-1:0] != '0)
                 || (r_addr < i_low) || (r_addr >= i_high)
                 || pg_diff[ppfl_pkg::DIFF_W-1]
                 || (pg_diff[ppfl_pkg::BP_W-1:0] >= NPAGES);
    end

    assign cur_slot = r_head_slot[r_cur];
    assign page_sum = i_bp + ppfl_pkg::BP_W'(cur_slot);
    assign cur_wide = 4'(r_cur);

    // status to controller
    assign o_sts.head_valid = r_head_vld[r_cur];
    assign o_sts.scan_last  = (r_cnt == CPU_LAST);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // link ram accesses
    assign ram_we    = i_cmd.free_commit && !free_bad;
    assign ram_waddr = free_slot;
    assign ram_wdata = {!r_head_vld[r_cur], r_head_vld[r_cur] ? cur_slot : {SW{1'b0}}};
    assign ram_re    = i_cmd.head_read;
    assign ram_raddr = cur_slot;

    // next values of request, heads and result
    always_comb begin
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_head_slot  = r_head_slot;
        n_head_vld   = r_head_vld;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_src    = r_res_src;
        if (i_cmd.load_req) begin
            n_cur  = cpu_mod;
            n_cnt  = '0;
            n_addr = i_addr;
        end
        if (i_cmd.scan_next) begin
            n_cur = (r_cur == CPU_LAST) ? '0 : r_cur + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.free_commit) begin
            n_res_addr = '0;
            n_res_src  = '0;
            if (free_bad) begin
                n_res_status = ppfl_pkg::ST_BAD;
            end else begin
                n_res_status       = ppfl_pkg::ST_OK;
                n_head_slot[r_cur] = free_slot;
                n_head_vld[r_cur]  = 1'b1;
            end
        end
        if (i_cmd.oom) begin
            n_res_addr   = '0;
            n_res_status = ppfl_pkg::ST_OOM;
            n_res_src    = '0;
        end
        if (i_cmd.pop_commit) begin
            n_res_addr   = {page_sum[ppfl_pkg::PG_W-1:0], {ppfl_pkg::PAGE_SHIFT{1'b0}}};
            n_res_status = ppfl_pkg::ST_OK;
            n_res_src    = cur_wide[2:0];
            if (ram_rdata[SW]) begin
                n_head_vld[r_cur]  = 1'b0;
                n_head_slot[r_cur] = '0;
            end else begin
                n_head_slot[r_cur] = ram_rdata[SW-1:0];
            end
        end
    end

    // output valid follows load and transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head_vld  <= n_head_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_cnt        <= n_cnt;
        r_addr       <= n_addr;
        r_head_slot  <= n_head_slot;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_src    <= n_res_src;
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_src    <= r_res_src;
        end
    end

    // next-link store: next slot with end-of-list flag on top
    ppfl_ram #(
        .WIDTH (SW + 1),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_page_addr  = r_out_addr;
    assign o_status     = r_out_status;
    assign o_source_cpu = r_out_src;

endmodule

// ----- rtl/per_cpu_page_free_list_allocator.sv -----
// per_cpu_page_free_list_allocator: top level with apb registers and channel wiring
// depends on ppfl_pkg, ppfl_if, ppfl_ctrl and ppfl_dp
//
// Each request gives one response. A free goes from transfer through S_FREE to S_DONE;
// an allocate goes through S_HEAD, which starts at the requester's own list and reads its
// head link or steps over an empty list, looking at one cpu list per cycle, then S_LINK,
// which unlinks the head with the registered read of the next-link ram, then S_DONE;
// out of memory goes from S_HEAD to S_DONE once all lists are tried. S_DONE waits
// until the output register can take the result. A new request is taken while the
// previous response still waits in the output register. The next-link ram needs no
// clearing after reset: a link is only read after a free has written it.
// Registers: mem_low_addr at 0x0, mem_high_addr at 0x4; write only while idle.
module per_cpu_page_free_list_allocator #(
    parameter int unsigned NUM_CPUS  = 8,
    parameter int unsigned NUM_PAGES = 32768
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    ppfl_req_if.sink      i_req,
    ppfl_rsp_if.source    o_rsp
);

    logic [31:0]                r_low, n_low;
    logic [31:0]                r_high, n_high;
    logic [ppfl_pkg::BP_W-1:0]  r_bp, n_bp;
    logic [32:0]                low_rnd;
    logic                       cfg_wr;

    ppfl_pkg::t_ctrl_cmd        w_cmd;
    ppfl_pkg::t_dp_status       w_sts;
    logic                       w_in_ready;

    // register write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign low_rnd = {1'b0, pwdata} + 33'((1 << ppfl_pkg::PAGE_SHIFT) - 1);
    assign prdata  = (paddr[2] == ppfl_pkg::REG_HIGH) ? r_high : r_low;

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        n_bp   = r_bp;
        if (cfg_wr && paddr[2] == ppfl_pkg::REG_LOW) begin
            n_low = pwdata;
            n_bp  = low_rnd[32:ppfl_pkg::PAGE_SHIFT];
        end
        if (cfg_wr && paddr[2] == ppfl_pkg::REG_HIGH) begin
            n_high = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= ppfl_pkg::LOW_RESET;
            r_high <= ppfl_pkg::HIGH_RESET;
            r_bp   <= ppfl_pkg::BP_RESET;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
            r_bp   <= n_bp;
        end
    end

    // sequencer
    ppfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_free  (i_req.opcode == ppfl_pkg::OP_FREE),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    // datapath
    ppfl_dp #(
        .NUM_CPUS  (NUM_CPUS),
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cpu        (i_req.requester_cpu),
        .i_addr       (i_req.phys_addr),
        .i_low        (r_low),
        .i_high       (r_high),
        .i_bp         (r_bp),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_page_addr  (o_rsp.page_addr),
        .o_status     (o_rsp.status),
        .o_source_cpu (o_rsp.source_cpu)
    );

    // a result is never moved over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("output register overwritten");

    // a failed request carries no page and no source cpu
    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ppfl_pkg::ST_OK)
        |-> (o_rsp.page_addr == '0 && o_rsp.source_cpu == '0))
        else $error("failed request returned a page");

    // no result is produced in the cycle after a request transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !w_cmd.out_load)
        else $error("result loaded too early");

    // requests are only taken with no request in progress
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.free_commit || w_cmd.head_read || w_cmd.pop_commit || w_cmd.scan_next)
        |-> !i_req.ready)
        else $error("request taken while busy");

endmodule
